// File: rtl/vts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the vertex transform stage.
// No dependencies; every other rtl file imports this package.
package vts_pkg;

	localparam int ENTRY_W        = 20;
	localparam int COL_W          = 60;
	localparam int POS_W          = 32;
	localparam int NRM_W          = 16;
	localparam int IDX_W          = 32;
	localparam int DEF_INDEX_BITS = 32;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 42;
	localparam int MUL_B_W = 21;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// APB port
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	// identity basis columns (1.0 on the diagonal)
	localparam logic [COL_W-1:0] COL_X_RST = 60'h1 << 16;
	localparam logic [COL_W-1:0] COL_Y_RST = 60'h1 << 36;
	localparam logic [COL_W-1:0] COL_Z_RST = 60'h1 << 56;

	typedef enum logic [2:0] {
		REG_COL_X   = 3'd0,
		REG_COL_Y   = 3'd1,
		REG_COL_Z   = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][COL_W-1:0] col;
		logic [2:0][POS_W-1:0] shift;
		logic                  ident;
	} cfg_t;

	// signed Q4.16 matrix entry m[col][row]
	function automatic logic signed [ENTRY_W-1:0] entry_of(cfg_t c, logic [1:0] col,
			logic [1:0] row);
		logic [COL_W-1:0] v;
		v = c.col[col];
		case (row)
			2'd0:    entry_of = v[19:0];
			2'd1:    entry_of = v[39:20];
			2'd2:    entry_of = v[59:40];
			default: entry_of = '0;
		endcase
	endfunction

endpackage

// File: rtl/vts_cfg.sv
`timescale 1ns / 1ps
// APB register file: basis columns and translation, plus identity detect.
// Depends on vts_pkg.
module vts_cfg
	import vts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [2:0][COL_W-1:0] col_q;
	logic [2:0][POS_W-1:0] shift_q;
	logic                  wr_en;
	logic [2:0]            widx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign widx   = paddr[5:3];

	// register writes, decoded on the 8-byte slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= COL_X_RST;
			col_q[1] <= COL_Y_RST;
			col_q[2] <= COL_Z_RST;
			shift_q  <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_COL_X:   col_q[0]   <= pwdata[COL_W-1:0];
				REG_COL_Y:   col_q[1]   <= pwdata[COL_W-1:0];
				REG_COL_Z:   col_q[2]   <= pwdata[COL_W-1:0];
				REG_SHIFT_X: shift_q[0] <= pwdata[POS_W-1:0];
				REG_SHIFT_Y: shift_q[1] <= pwdata[POS_W-1:0];
				REG_SHIFT_Z: shift_q[2] <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		case (widx)
			REG_COL_X:   prdata = {4'b0, col_q[0]};
			REG_COL_Y:   prdata = {4'b0, col_q[1]};
			REG_COL_Z:   prdata = {4'b0, col_q[2]};
			REG_SHIFT_X: prdata = {32'b0, shift_q[0]};
			REG_SHIFT_Y: prdata = {32'b0, shift_q[1]};
			REG_SHIFT_Z: prdata = {32'b0, shift_q[2]};
			default:     prdata = '0;
		endcase
	end

	assign cfg.col   = col_q;
	assign cfg.shift = shift_q;
	assign cfg.ident = (col_q[0] == COL_X_RST) && (col_q[1] == COL_Y_RST) &&
		(col_q[2] == COL_Z_RST) && (shift_q == '0);

endmodule

// File: rtl/vts_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on vts_pkg.
module vts_mul
	import vts_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= a * b;
		end
	end

endmodule

// File: rtl/vts_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath: MAC schedule on the shared multiplier, normal
// scaling, bit-serial square root and restoring divide, output register.
// Depends on vts_pkg; drives the vts_mul instance through the top level.
module vts_core
	import vts_pkg::*;
#(
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic signed [POS_W-1:0]    in_pos_x,
	input  logic signed [POS_W-1:0]    in_pos_y,
	input  logic signed [POS_W-1:0]    in_pos_z,
	input  logic signed [NRM_W-1:0]    in_nrm_x,
	input  logic signed [NRM_W-1:0]    in_nrm_y,
	input  logic signed [NRM_W-1:0]    in_nrm_z,
	input  logic signed [POS_W-1:0]    in_tex_u,
	input  logic signed [POS_W-1:0]    in_tex_v,
	input  logic [IDX_W-1:0]           in_corner_a,
	input  logic [IDX_W-1:0]           in_corner_b,
	input  logic [IDX_W-1:0]           in_corner_c,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       out_kind,
	output logic [IDX_W-1:0]           out_index_a,
	output logic [IDX_W-1:0]           out_index_b,
	output logic [IDX_W-1:0]           out_index_c,
	output logic signed [POS_W-1:0]    out_pos_x,
	output logic signed [POS_W-1:0]    out_pos_y,
	output logic signed [POS_W-1:0]    out_pos_z,
	output logic signed [NRM_W-1:0]    out_nrm_x,
	output logic signed [NRM_W-1:0]    out_nrm_y,
	output logic signed [NRM_W-1:0]    out_nrm_z,
	output logic signed [POS_W-1:0]    out_tex_u,
	output logic signed [POS_W-1:0]    out_tex_v,
	output logic                       mul_en,
	output logic signed [MUL_A_W-1:0]  mul_a,
	output logic signed [MUL_B_W-1:0]  mul_b,
	input  logic signed [PROD_W-1:0]   mul_prod
);

	// accumulator destinations
	localparam logic [4:0] D_DET  = 5'd9;
	localparam logic [4:0] D_POS0 = 5'd10;
	localparam logic [4:0] D_W0   = 5'd13;
	localparam logic [4:0] D_SUM  = 5'd16;

	// step numbers of the MAC schedule
	localparam logic [5:0] ST_DET   = 6'd18;
	localparam logic [5:0] ST_POS   = 6'd21;
	localparam logic [5:0] ST_NRM   = 6'd30;
	localparam logic [5:0] ST_SQ    = 6'd39;
	localparam logic [5:0] ST_SHORT = 6'd20;
	localparam logic [5:0] ST_LONG  = 6'd38;
	localparam logic [5:0] ST_SQEND = 6'd44;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MAC   = 9'b000000010,
		S_DRAIN = 9'b000000100,
		S_PREP  = 9'b000001000,
		S_SHIFT = 9'b000010000,
		S_SQRT  = 9'b000100000,
		S_DIVLD = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	function automatic logic [1:0] nxt3(logic [1:0] x);
		nxt3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
	endfunction

	// {j/3, j%3} for j in 0..8
	function automatic logic [3:0] split3(logic [3:0] j);
		case (j)
			4'd0:    split3 = {2'd0, 2'd0};
			4'd1:    split3 = {2'd0, 2'd1};
			4'd2:    split3 = {2'd0, 2'd2};
			4'd3:    split3 = {2'd1, 2'd0};
			4'd4:    split3 = {2'd1, 2'd1};
			4'd5:    split3 = {2'd1, 2'd2};
			4'd6:    split3 = {2'd2, 2'd0};
			4'd7:    split3 = {2'd2, 2'd1};
			4'd8:    split3 = {2'd2, 2'd2};
			default: split3 = 4'd0;
		endcase
	endfunction

	function automatic logic [3:0] adj_idx(logic [1:0] c, logic [1:0] r);
		adj_idx = {c, 1'b0} + {2'b0, c} + {2'b0, r};
	endfunction

	function automatic logic signed [MUL_A_W-1:0] ent_a(logic signed [ENTRY_W-1:0] e);
		ent_a = {{(MUL_A_W-ENTRY_W){e[ENTRY_W-1]}}, e};
	endfunction

	function automatic logic signed [MUL_B_W-1:0] ent_b(logic signed [ENTRY_W-1:0] e);
		ent_b = {e[ENTRY_W-1], e};
	endfunction

	state_t state_q;
	logic [5:0] st_q, st_end_q;
	logic       sq_phase_q;

	// captured item
	logic                     type_q;
	logic [2:0][POS_W-1:0]    pin_q;
	logic [2:0][NRM_W-1:0]    nin_q;
	logic [POS_W-1:0]         tex_u_q, tex_v_q;
	logic [IDX_W-1:0]         ca_q, cb_q, cc_q;

	// MAC results
	logic signed [40:0]       adj_q [9];
	logic signed [61:0]       det_q;
	logic [2:0][POS_W-1:0]    pos_q;
	logic signed [56:0]       w_q [3];
	logic signed [63:0]       acc_q;

	// accumulate stage controls
	logic       vld_s1, first_s1, last_s1, sub_s1, shl_s1;
	logic [4:0] dest_s1;

	// normal scaling
	logic [55:0]           mag_q [3];
	logic [2:0]            neg_q;
	logic [2:0][NRM_W-1:0] nrm_q;
	logic [63:0]           sq_s_q, sq_r_q;
	logic [4:0]            sq_i_q;
	logic [31:0]           len_q;
	logic [1:0]            comp_q;
	logic [3:0]            di_q;
	logic [46:0]           rem_q;
	logic [14:0]           quo_q;

	logic [INDEX_BITS-1:0] cnt_q;
	logic                  mirrored;
	logic                  accept;
	logic                  out_free;

	// step decode
	logic       op_first, op_last, op_sub, op_shl;
	logic [4:0] op_dest;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign mirrored = det_q[61];
	assign out_free = !out_valid || !out_stall;
	assign mul_en   = (state_q == S_MAC);

	// operand selection for the current step
	always_comb begin
		logic [3:0] j;
		logic [3:0] rc;
		logic [1:0] cc, rr, ca, cb, r1, r2;
		j        = '0;
		rc       = '0;
		cc       = '0;
		rr       = '0;
		ca       = '0;
		cb       = '0;
		r1       = '0;
		r2       = '0;
		mul_a    = '0;
		mul_b    = '0;
		op_first = 1'b0;
		op_last  = 1'b0;
		op_sub   = 1'b0;
		op_shl   = 1'b0;
		op_dest  = '0;
		if (st_q < ST_DET) begin
			// adjugate: two products per entry
			j  = st_q[4:1];
			rc = split3(j);
			cc = rc[3:2];
			rr = rc[1:0];
			ca = nxt3(cc);
			cb = nxt3(ca);
			r1 = nxt3(rr);
			r2 = nxt3(r1);
			op_dest = {1'b0, j};
			if (!st_q[0]) begin
				mul_a    = ent_a(entry_of(cfg, ca, r1));
				mul_b    = ent_b(entry_of(cfg, cb, r2));
				op_first = 1'b1;
			end else begin
				mul_a   = ent_a(entry_of(cfg, ca, r2));
				mul_b   = ent_b(entry_of(cfg, cb, r1));
				op_sub  = 1'b1;
				op_last = 1'b1;
			end
		end else if (st_q < ST_POS) begin
			// determinant along the first column
			rr       = 2'(st_q - ST_DET);
			mul_a    = {adj_q[{2'b0, rr}][40], adj_q[{2'b0, rr}]};
			mul_b    = ent_b(entry_of(cfg, 2'd0, rr));
			op_first = (rr == 2'd0);
			op_last  = (rr == 2'd2);
			op_dest  = D_DET;
		end else if (st_q < ST_NRM) begin
			// position rows
			rc       = split3(4'(st_q - ST_POS));
			rr       = rc[3:2];
			cc       = rc[1:0];
			mul_a    = {{(MUL_A_W-POS_W){pin_q[cc][POS_W-1]}}, pin_q[cc]};
			mul_b    = ent_b(entry_of(cfg, cc, rr));
			op_first = (cc == 2'd0);
			op_last  = (cc == 2'd2);
			op_dest  = D_POS0 + {3'b0, rr};
		end else if (st_q < ST_SQ) begin
			// adjugate times normal
			rc       = split3(4'(st_q - ST_NRM));
			rr       = rc[3:2];
			cc       = rc[1:0];
			mul_a    = {adj_q[adj_idx(cc, rr)][40], adj_q[adj_idx(cc, rr)]};
			mul_b    = {{(MUL_B_W-NRM_W){nin_q[cc][NRM_W-1]}}, nin_q[cc]};
			op_first = (cc == 2'd0);
			op_last  = (cc == 2'd2);
			op_dest  = D_W0 + {3'b0, rr};
		end else begin
			// sum of squares, each square as high and low halves
			j        = 4'(st_q - ST_SQ);
			rr       = j[2:1];
			mul_a    = {12'b0, mag_q[rr][29:0]};
			mul_b    = j[0] ? {6'b0, mag_q[rr][14:0]} : {6'b0, mag_q[rr][29:15]};
			op_shl   = !j[0];
			op_first = (j == 4'd0);
			op_last  = (j == 4'd5);
			op_dest  = D_SUM;
		end
	end

	// accumulate stage
	logic signed [63:0] acc_sum;
	logic signed [63:0] acc_init;
	logic signed [63:0] acc_prod;
	logic signed [63:0] acc_rnd;
	logic [1:0]         pos_row;
	logic [1:0]         w_row;
	logic [POS_W-1:0]   pos_sat;

	always_comb begin
		pos_row  = 2'(dest_s1 - D_POS0);
		w_row    = 2'(dest_s1 - D_W0);
		acc_init = '0;
		if (dest_s1 >= D_POS0 && dest_s1 < D_W0) begin
			acc_init = {{16{cfg.shift[pos_row][POS_W-1]}}, cfg.shift[pos_row], 16'h8000};
		end
		acc_prod = shl_s1 ? {mul_prod[48:0], 15'b0} : {mul_prod[PROD_W-1], mul_prod};
		acc_sum  = (first_s1 ? acc_init : acc_q) + (sub_s1 ? -acc_prod : acc_prod);
		acc_rnd  = acc_sum >>> 16;
		if (acc_rnd[63:31] == '0 || acc_rnd[63:31] == '1) begin
			pos_sat = acc_rnd[31:0];
		end else begin
			pos_sat = acc_rnd[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= mul_en;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= op_first;
		last_s1  <= op_last;
		sub_s1   <= op_sub;
		shl_s1   <= op_shl;
		dest_s1  <= op_dest;
		if (vld_s1) begin
			acc_q <= acc_sum;
			if (last_s1) begin
				if (dest_s1 < D_DET) begin
					adj_q[dest_s1[3:0]] <= acc_sum[40:0];
				end else if (dest_s1 == D_DET) begin
					det_q <= acc_sum[61:0];
				end else if (dest_s1 < D_W0) begin
					pos_q[pos_row] <= pos_sat;
				end else if (dest_s1 < D_SUM) begin
					w_q[w_row] <= acc_sum[56:0];
				end
			end
		end
	end

	// square root step
	logic [63:0] sq_bit, sq_t, sq_r_nx, sq_s_nx;
	always_comb begin
		sq_bit = 64'h1 << {sq_i_q, 1'b0};
		sq_t   = sq_r_q + sq_bit;
		if (sq_s_q >= sq_t) begin
			sq_s_nx = sq_s_q - sq_t;
			sq_r_nx = (sq_r_q >> 1) + sq_bit;
		end else begin
			sq_s_nx = sq_s_q;
			sq_r_nx = sq_r_q >> 1;
		end
	end

	// divide step
	logic [46:0] dv;
	logic [46:0] rem_nx;
	logic [14:0] quo_nx;
	logic [15:0] qmag;
	always_comb begin
		dv     = {15'b0, len_q} << di_q;
		rem_nx = rem_q;
		quo_nx = quo_q;
		if (rem_q >= dv) begin
			rem_nx       = rem_q - dv;
			quo_nx[di_q] = 1'b1;
		end
		qmag = {1'b0, quo_nx};
	end

	// normal components after the mirror sign
	logic signed [56:0] wsel [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			wsel[r] = mirrored ? -w_q[r] : w_q[r];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (accept) state_q <= S_MAC;
				S_MAC:   if (st_q == st_end_q) state_q <= S_DRAIN;
				S_DRAIN: begin
					if (sq_phase_q) state_q <= S_SQRT;
					else if (type_q || cfg.ident) state_q <= S_DONE;
					else state_q <= S_PREP;
				end
				S_PREP: begin
					if (wsel[0] == '0 && wsel[1] == '0 && wsel[2] == '0) state_q <= S_DONE;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (mag_q[0][55:30] == '0 && mag_q[1][55:30] == '0 &&
							mag_q[2][55:30] == '0) begin
						state_q <= S_MAC;
					end
				end
				S_SQRT: begin
					if (sq_i_q == '0) state_q <= (sq_r_nx == '0) ? S_DONE : S_DIVLD;
				end
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (di_q == '0) state_q <= (comp_q == 2'd2) ? S_DONE : S_DIVLD;
				end
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				type_q     <= req_type;
				pin_q      <= {in_pos_z, in_pos_y, in_pos_x};
				nin_q      <= {in_nrm_z, in_nrm_y, in_nrm_x};
				tex_u_q    <= in_tex_u;
				tex_v_q    <= in_tex_v;
				ca_q       <= in_corner_a;
				cb_q       <= in_corner_b;
				cc_q       <= in_corner_c;
				st_q       <= '0;
				st_end_q   <= (req_type || cfg.ident) ? ST_SHORT : ST_LONG;
				sq_phase_q <= 1'b0;
			end
			S_MAC: st_q <= st_q + 6'd1;
			S_DRAIN: begin
				sq_s_q <= {2'b0, acc_sum[61:0]};
				sq_r_q <= '0;
				sq_i_q <= 5'd31;
			end
			S_PREP: begin
				nrm_q <= '0;
				for (int r = 0; r < 3; r++) begin
					neg_q[r] <= wsel[r][56];
					mag_q[r] <= wsel[r][56] ? 56'(-wsel[r]) : wsel[r][55:0];
				end
			end
			S_SHIFT: begin
				if (mag_q[0][55:30] == '0 && mag_q[1][55:30] == '0 &&
						mag_q[2][55:30] == '0) begin
					st_q       <= ST_SQ;
					st_end_q   <= ST_SQEND;
					sq_phase_q <= 1'b1;
				end else begin
					for (int r = 0; r < 3; r++) begin
						mag_q[r] <= mag_q[r] >> 1;
					end
				end
			end
			S_SQRT: begin
				sq_s_q <= sq_s_nx;
				sq_r_q <= sq_r_nx;
				sq_i_q <= sq_i_q - 5'd1;
				len_q  <= sq_r_nx[31:0];
				comp_q <= '0;
			end
			S_DIVLD: begin
				rem_q <= {3'b0, mag_q[comp_q][29:0], 14'b0} + {16'b0, len_q[31:1]};
				quo_q <= '0;
				di_q  <= 4'd14;
			end
			S_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				di_q  <= di_q - 4'd1;
				if (di_q == '0) begin
					nrm_q[comp_q] <= neg_q[comp_q] ? -qmag : qmag;
					comp_q        <= comp_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// result register and vertex counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid <= 1'b1;
			if (!type_q) cnt_q <= cnt_q + 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_kind <= type_q;
			if (type_q) begin
				out_index_a <= ca_q;
				out_index_b <= mirrored ? cc_q : cb_q;
				out_index_c <= mirrored ? cb_q : cc_q;
				out_pos_x   <= '0;
				out_pos_y   <= '0;
				out_pos_z   <= '0;
				out_nrm_x   <= '0;
				out_nrm_y   <= '0;
				out_nrm_z   <= '0;
				out_tex_u   <= '0;
				out_tex_v   <= '0;
			end else begin
				out_index_a <= IDX_W'(cnt_q);
				out_index_b <= '0;
				out_index_c <= '0;
				out_tex_u   <= tex_u_q;
				out_tex_v   <= tex_v_q;
				if (cfg.ident) begin
					out_pos_x <= pin_q[0];
					out_pos_y <= pin_q[1];
					out_pos_z <= pin_q[2];
					out_nrm_x <= nin_q[0];
					out_nrm_y <= nin_q[1];
					out_nrm_z <= nin_q[2];
				end else begin
					out_pos_x <= pos_q[0];
					out_pos_y <= pos_q[1];
					out_pos_z <= pos_q[2];
					out_nrm_x <= nrm_q[0];
					out_nrm_y <= nrm_q[1];
					out_nrm_z <= nrm_q[2];
				end
			end
		end
	end

endmodule

// File: rtl/vertex_transform_stage.sv
`timescale 1ns / 1ps
// Top level of the vertex transform stage: APB registers, shared multiplier
// and sequencer core. Depends on vts_pkg, vts_cfg, vts_mul and vts_core.
//
// Takes one item at a time; in_stall stays high from acceptance until the
// result is loaded into the output register, which can hold a finished beat
// while the next item is accepted. Triangle items and vertices under the
// identity transform run 21 multiplies, for the adjugate and determinant,
// on the single shared 42x21 multiplier. Other vertices run 39
// multiply-accumulate steps, normal prescaling, 6 steps for the squared
// length, a bit-serial square root and three restoring divides; a vertex
// whose transformed normal is zero stops after its zero check, before the
// prescaling. Registers sit at byte address 8*i; the user must write them
// only while the block holds no item, which the block itself does not enforce.
module vertex_transform_stage
	import vts_pkg::*;
#(
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]   prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic signed [POS_W-1:0] in_pos_x,
	input  logic signed [POS_W-1:0] in_pos_y,
	input  logic signed [POS_W-1:0] in_pos_z,
	input  logic signed [NRM_W-1:0] in_nrm_x,
	input  logic signed [NRM_W-1:0] in_nrm_y,
	input  logic signed [NRM_W-1:0] in_nrm_z,
	input  logic signed [POS_W-1:0] in_tex_u,
	input  logic signed [POS_W-1:0] in_tex_v,
	input  logic [IDX_W-1:0]        in_corner_a,
	input  logic [IDX_W-1:0]        in_corner_b,
	input  logic [IDX_W-1:0]        in_corner_c,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    out_kind,
	output logic [IDX_W-1:0]        out_index_a,
	output logic [IDX_W-1:0]        out_index_b,
	output logic [IDX_W-1:0]        out_index_c,
	output logic signed [POS_W-1:0] out_pos_x,
	output logic signed [POS_W-1:0] out_pos_y,
	output logic signed [POS_W-1:0] out_pos_z,
	output logic signed [NRM_W-1:0] out_nrm_x,
	output logic signed [NRM_W-1:0] out_nrm_y,
	output logic signed [NRM_W-1:0] out_nrm_z,
	output logic signed [POS_W-1:0] out_tex_u,
	output logic signed [POS_W-1:0] out_tex_v
);

	cfg_t                      cfg;
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_prod;

	vts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vts_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	vts_core #(
		.INDEX_BITS (INDEX_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.in_pos_x    (in_pos_x),
		.in_pos_y    (in_pos_y),
		.in_pos_z    (in_pos_z),
		.in_nrm_x    (in_nrm_x),
		.in_nrm_y    (in_nrm_y),
		.in_nrm_z    (in_nrm_z),
		.in_tex_u    (in_tex_u),
		.in_tex_v    (in_tex_v),
		.in_corner_a (in_corner_a),
		.in_corner_b (in_corner_b),
		.in_corner_c (in_corner_c),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_index_a (out_index_a),
		.out_index_b (out_index_b),
		.out_index_c (out_index_c),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y),
		.out_pos_z   (out_pos_z),
		.out_nrm_x   (out_nrm_x),
		.out_nrm_y   (out_nrm_y),
		.out_nrm_z   (out_nrm_z),
		.out_tex_u   (out_tex_u),
		.out_tex_v   (out_tex_v),
		.mul_en      (mul_en),
		.mul_a       (mul_a),
		.mul_b       (mul_b),
		.mul_prod    (mul_prod)
	);

endmodule
